// ===== rtl/dau_pkg.sv =====
// Shared types and constants for the duration arithmetic unit.
`timescale 1ns / 1ps

package dau_pkg;

    localparam logic [29:0] NANOS_PER_SEC = 30'd1000000000;
    localparam logic [29:0] NANOS_MAX     = 30'd999999999;
    localparam int          DIV_A_STEPS   = 64;
    localparam int          DIV_B_STEPS   = 30;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // One slot of the divider pipeline plus the operands carried alongside.
    typedef struct packed {
        logic        valid;
        mode_t       mode;
        logic        sat;
        status_t     st;
        logic [31:0] den;
        logic [31:0] rem;
        logic [63:0] nq;
        logic [63:0] secs;
        logic [29:0] nanos;
        logic [29:0] an;
    } pipe_t;

endpackage

// ===== rtl/duration_arithmetic_unit.sv =====
// Top level: seconds/nanoseconds add, subtract, multiply and divide pipeline.
// Stages, in order: input register, two operand stages, 64 quotient steps, one rescale
// stage, 30 nanosecond steps, output.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset: aresetn clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module duration_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], saturate[2], a_secs[66:3], a_nanos[96:67], b_secs[160:97],
    // b_nanos[190:161], factor[222:191], zero[223]
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_secs[63:0], res_nanos[95:64], status[97:96], zero[103:98]
    output logic [103:0] m_tdata
);

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic        sat;
        logic [63:0] as;
        logic [29:0] an;
        logic [63:0] bs;
        logic [29:0] bn;
        logic [31:0] f;
    } in_t;

    typedef struct packed {
        logic             valid;
        dau_pkg::mode_t   mode;
        logic             sat;
        dau_pkg::status_t st;
        logic [63:0]      as;
        logic [29:0]      an;
        logic [31:0]      f;
        logic [63:0]      secs;
        logic [29:0]      nanos;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [61:0]      tot;
    } p1_t;

    localparam int NA = dau_pkg::DIV_A_STEPS;
    localparam int NB = dau_pkg::DIV_B_STEPS;

    logic adv;
    in_t  in_reg;
    p1_t  p1_reg, p1_next;
    dau_pkg::pipe_t p2_reg, p2_next;
    dau_pkg::pipe_t pm_reg, pm_next;
    dau_pkg::pipe_t a_chain [NA+1];
    dau_pkg::pipe_t b_chain [NB+1];
    logic         out_valid_reg;
    logic [103:0] out_data_reg, out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (adv) begin
            in_reg.valid <= s_tvalid;
        end
        if (adv) begin
            in_reg.mode  <= s_tdata[1:0];
            in_reg.sat   <= s_tdata[2];
            in_reg.as    <= s_tdata[66:3];
            in_reg.an    <= s_tdata[96:67];
            in_reg.bs    <= s_tdata[160:97];
            in_reg.bn    <= s_tdata[190:161];
            in_reg.f     <= s_tdata[222:191];
        end
    end

    // Operand stage: clamp, add/subtract, partial products, divide-by-zero check.
    logic [29:0] an_c, bn_c;
    logic [30:0] nsum;
    logic        carry;
    logic [64:0] ssum;
    logic        borrow;
    logic [30:0] ndiff;
    logic [64:0] sdiff;

    always_comb begin
        an_c   = (in_reg.an > dau_pkg::NANOS_MAX) ? dau_pkg::NANOS_MAX : in_reg.an;
        bn_c   = (in_reg.bn > dau_pkg::NANOS_MAX) ? dau_pkg::NANOS_MAX : in_reg.bn;
        nsum   = {1'b0, an_c} + {1'b0, bn_c};
        carry  = (nsum >= {1'b0, dau_pkg::NANOS_PER_SEC});
        ssum   = {1'b0, in_reg.as} + {1'b0, in_reg.bs} + {64'd0, carry};
        borrow = (an_c < bn_c);
        ndiff  = borrow ? ({1'b0, an_c} + {1'b0, dau_pkg::NANOS_PER_SEC} - {1'b0, bn_c})
                        : ({1'b0, an_c} - {1'b0, bn_c});
        sdiff  = {1'b0, in_reg.as} - {1'b0, in_reg.bs} - {64'd0, borrow};

        p1_next       = '0;
        p1_next.valid = in_reg.valid && aresetn;
        p1_next.mode  = dau_pkg::mode_t'(in_reg.mode);
        p1_next.sat   = in_reg.sat;
        p1_next.as    = in_reg.as;
        p1_next.an    = an_c;
        p1_next.f     = in_reg.f;
        p1_next.lo    = {32'd0, in_reg.as[31:0]} * {32'd0, in_reg.f};
        p1_next.hi    = {32'd0, in_reg.as[63:32]} * {32'd0, in_reg.f};
        p1_next.tot   = {32'd0, an_c} * {30'd0, in_reg.f};
        p1_next.st    = dau_pkg::ST_OK;
        unique case (dau_pkg::mode_t'(in_reg.mode))
            dau_pkg::MODE_ADD: begin
                p1_next.secs  = ssum[63:0];
                p1_next.nanos = carry ? (nsum[29:0] - dau_pkg::NANOS_PER_SEC) : nsum[29:0];
                if (ssum[64]) p1_next.st = dau_pkg::ST_OVER;
            end
            dau_pkg::MODE_SUB: begin
                p1_next.secs  = sdiff[63:0];
                p1_next.nanos = ndiff[29:0];
                if (sdiff[64]) p1_next.st = dau_pkg::ST_UNDER;
            end
            dau_pkg::MODE_MUL: begin
                p1_next.secs  = '0;
                p1_next.nanos = '0;
            end
            dau_pkg::MODE_DIV: begin
                p1_next.secs  = '0;
                p1_next.nanos = '0;
                if (in_reg.f == 32'd0) p1_next.st = dau_pkg::ST_DIVZ;
            end
            default: begin
                p1_next.secs  = '0;
                p1_next.nanos = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv || !aresetn) begin
            p1_reg <= p1_next;
        end
    end

    // Product assembly and divider setup.
    logic [64:0] psum;

    always_comb begin
        psum          = {1'b0, p1_reg.hi[31:0], 32'd0} + {1'b0, p1_reg.lo};
        p2_next       = '0;
        p2_next.valid = p1_reg.valid && aresetn;
        p2_next.mode  = p1_reg.mode;
        p2_next.sat   = p1_reg.sat;
        p2_next.st    = p1_reg.st;
        p2_next.an    = p1_reg.an;
        p2_next.secs  = p1_reg.secs;
        p2_next.nanos = p1_reg.nanos;
        p2_next.rem   = '0;
        if (p1_reg.mode == dau_pkg::MODE_MUL) begin
            p2_next.den  = {2'd0, dau_pkg::NANOS_PER_SEC};
            p2_next.nq   = {2'd0, p1_reg.tot};
            p2_next.secs = psum[63:0];
            if (p1_reg.hi[63:32] != 32'd0 || psum[64]) p2_next.st = dau_pkg::ST_OVER;
        end else begin
            p2_next.den = p1_reg.f;
            p2_next.nq  = p1_reg.as;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv || !aresetn) begin
            p2_reg <= p2_next;
        end
    end

    assign a_chain[0] = p2_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NA; gi++) begin : g_div_a
            dau_div_step u_step (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (adv),
                .d_in    (a_chain[gi]),
                .d_out   (a_chain[gi+1])
            );
        end
    endgenerate

    // Rescale stage: remainder into nanoseconds, or add carried seconds.
    logic [61:0] num2;
    logic [64:0] msum;

    always_comb begin
        num2    = {30'd0, a_chain[NA].rem} * {32'd0, dau_pkg::NANOS_PER_SEC}
                  + {32'd0, a_chain[NA].an};
        msum    = {1'b0, a_chain[NA].secs} + {1'b0, a_chain[NA].nq};
        pm_next = a_chain[NA];
        pm_next.valid = a_chain[NA].valid && aresetn;
        if (a_chain[NA].mode == dau_pkg::MODE_MUL) begin
            pm_next.secs  = msum[63:0];
            pm_next.nanos = a_chain[NA].rem[29:0];
            if (msum[64]) pm_next.st = dau_pkg::ST_OVER;
        end else if (a_chain[NA].mode == dau_pkg::MODE_DIV) begin
            pm_next.secs = a_chain[NA].nq;
            pm_next.rem  = num2[61:30];
            pm_next.nq   = {num2[29:0], 34'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv || !aresetn) begin
            pm_reg <= pm_next;
        end
    end

    assign b_chain[0] = pm_reg;

    generate
        for (gi = 0; gi < NB; gi++) begin : g_div_b
            dau_div_step u_step (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (adv),
                .d_in    (b_chain[gi]),
                .d_out   (b_chain[gi+1])
            );
        end
    endgenerate

    // Result formatting.
    dau_pkg::pipe_t fin;
    logic [63:0]    r_secs;
    logic [31:0]    r_nanos;

    always_comb begin
        fin     = b_chain[NB];
        r_secs  = fin.secs;
        r_nanos = {2'd0, fin.nanos};
        if (fin.mode == dau_pkg::MODE_DIV) begin
            r_nanos = {2'd0, fin.nq[29:0]};
        end
        if (fin.st != dau_pkg::ST_OK) begin
            r_secs  = '0;
            r_nanos = '0;
        end
        if (fin.st == dau_pkg::ST_OVER && fin.sat) begin
            r_secs  = '1;
            r_nanos = '1;
        end
        out_data_next = {6'd0, fin.st, r_nanos, r_secs};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= fin.valid;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[97:96] == dau_pkg::ST_DIVZ || m_tdata[97:96] == dau_pkg::ST_UNDER)
        |-> m_tdata[95:0] == 96'd0)
        else $error("failed divide or subtract returned nonzero duration");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[97:96] == dau_pkg::ST_OK
        |-> m_tdata[95:64] < {2'd0, dau_pkg::NANOS_PER_SEC})
        else $error("nanoseconds out of range on good result");

endmodule

// ===== rtl/dau_div_step.sv =====
// One restoring-division step with its pipeline register.
`timescale 1ns / 1ps

module dau_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  dau_pkg::pipe_t d_in,
    output dau_pkg::pipe_t d_out
);

    dau_pkg::pipe_t stage_reg;
    dau_pkg::pipe_t stage_next;
    logic [32:0]    trial;
    logic [32:0]    diff;
    logic           ge;

    always_comb begin
        trial      = {d_in.rem, d_in.nq[63]};
        diff       = trial - {1'b0, d_in.den};
        ge         = (trial >= {1'b0, d_in.den});
        stage_next = d_in;
        stage_next.valid = d_in.valid && aresetn;
        stage_next.rem = ge ? diff[31:0] : trial[31:0];
        stage_next.nq  = {d_in.nq[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en || !aresetn) begin
            stage_reg <= stage_next;
        end
    end

    assign d_out = stage_reg;

endmodule
